>>> hw/rtl/lslf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_pkg
// Shared constants, widths and types for the three-channel line-fit block.
// ----------------------------------------------------------------------------
package lslf_pkg;

    localparam int IN_W        = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SAMPLES = 1024;
    localparam int FRAC_BITS   = 16;

    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SX_W    = SAMPLE_BITS + CNT_W;
    localparam int SXX_W   = 2 * SAMPLE_BITS + CNT_W - 1;
    localparam int MUL_AW  = SX_W;
    localparam int MUL_BW  = SXX_W;
    localparam int PROD_W  = MUL_AW + MUL_BW + 1;
    localparam int MCNT_W  = $clog2(MUL_AW + 1);
    localparam int DVD_W   = PROD_W + FRAC_BITS + 1;
    localparam int DCNT_W  = $clog2(DVD_W + 1);
    localparam int OUT_W   = 48;
    localparam int Q_W     = OUT_W + 1;
    localparam int CHAN_W  = 2;
    localparam int NCHAN   = 3;

    // multiplier operand pairs
    typedef enum logic [2:0] {
        MOP_N_SXX  = 3'd0,
        MOP_SX_SX  = 3'd1,
        MOP_SY_SXX = 3'd2,
        MOP_SX_SXY = 3'd3,
        MOP_N_SXY  = 3'd4,
        MOP_SX_SY  = 3'd5
    } t_mop;

    typedef enum logic {
        DSEL_A = 1'b0,
        DSEL_B = 1'b1
    } t_dsel;

    typedef struct packed {
        logic              load;
        logic              mul_start;
        t_mop              mop;
        logic              div_start;
        t_dsel             dsel;
        logic              emit;
        logic              clear;
        logic [CHAN_W-1:0] chan;
    } t_cmd;

    typedef struct packed {
        logic mul_fin;
        logic div_fin;
        logic singular;
    } t_sts;

endpackage
`default_nettype wire

>>> hw/rtl/least_squares_line_fit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// least_squares_line_fit
// Three-channel straight-line least-squares fit with Q31.16 results.
// ----------------------------------------------------------------------------
// Usage:
//   A sample (x and three responses) is taken when start is high and busy is
//   low. Samples stream in at one per clock: each is summed the cycle after
//   it is taken. Samples past capacity are dropped and flagged.
//   A sample with i_final_sample set starts the fit; busy stays high until
//   all three results are out. Results appear on o_channel, o_intercept,
//   o_slope, o_singular, o_overflowed and o_run_end for exactly one cycle,
//   marked by o_valid, channel 0 first; o_run_end marks the third. The
//   receiver cannot stall: each result must be taken when shown.
//   Sequence: the fit runs on one bit-serial multiplier and one restoring
//   divider. The final sample is summed first, then two products form the
//   denominator; then per channel four products form the two numerators,
//   two divisions give intercept and slope and the result is issued; a
//   singular set skips the divisions. Afterwards all sums clear.
//   Reset (synchronous, active low) clears the sums, count and drop flag.
// ----------------------------------------------------------------------------
module least_squares_line_fit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic signed [lslf_pkg::IN_W-1:0]       i_x_value,
    input  wire logic signed [lslf_pkg::IN_W-1:0]       i_resp_one,
    input  wire logic signed [lslf_pkg::IN_W-1:0]       i_resp_two,
    input  wire logic signed [lslf_pkg::IN_W-1:0]       i_resp_three,
    input  wire logic                                   i_final_sample,
    output logic                                        o_valid,
    output logic [lslf_pkg::CHAN_W-1:0]                 o_channel,
    output logic signed [lslf_pkg::OUT_W-1:0]           o_intercept,
    output logic signed [lslf_pkg::OUT_W-1:0]           o_slope,
    output logic                                        o_singular,
    output logic                                        o_overflowed,
    output logic                                        o_run_end
);

    lslf_pkg::t_cmd cmd;
    lslf_pkg::t_sts sts;

    lslf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_final_sample (i_final_sample),
        .i_sts          (sts),
        .o_cmd          (cmd),
        .busy           (busy)
    );

    lslf_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_x_value    (i_x_value),
        .i_resp_one   (i_resp_one),
        .i_resp_two   (i_resp_two),
        .i_resp_three (i_resp_three),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_channel    (o_channel),
        .o_intercept  (o_intercept),
        .o_slope      (o_slope),
        .o_singular   (o_singular),
        .o_overflowed (o_overflowed),
        .o_run_end    (o_run_end)
    );

endmodule
`default_nettype wire

>>> hw/rtl/lslf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_ctrl
// Sequencer: takes samples, then steps the shared multiplier and divider
// through the fit of each channel and issues the results.
// ----------------------------------------------------------------------------
module lslf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          i_final_sample,
    input  lslf_pkg::t_sts     i_sts,
    output lslf_pkg::t_cmd     o_cmd,
    output logic               busy
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LAST  = 7'b0000010,
        S_MGO   = 7'b0000100,
        S_MWAIT = 7'b0001000,
        S_DGO   = 7'b0010000,
        S_DWAIT = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state                        r_state, n_state;
    lslf_pkg::t_mop                r_mop, n_mop;
    lslf_pkg::t_dsel               r_dsel, n_dsel;
    logic [lslf_pkg::CHAN_W-1:0]   r_chan, n_chan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mop   <= lslf_pkg::MOP_N_SXX;
            r_dsel  <= lslf_pkg::DSEL_A;
            r_chan  <= '0;
        end else begin
            r_state <= n_state;
            r_mop   <= n_mop;
            r_dsel  <= n_dsel;
            r_chan  <= n_chan;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_mop           = r_mop;
        n_dsel          = r_dsel;
        n_chan          = r_chan;
        o_cmd           = '0;
        o_cmd.mop       = r_mop;
        o_cmd.dsel      = r_dsel;
        o_cmd.chan      = r_chan;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
                if (start && i_final_sample) begin
                    n_state = S_LAST;
                    n_mop   = lslf_pkg::MOP_N_SXX;
                    n_chan  = '0;
                end
            end
            S_LAST: n_state = S_MGO;
            S_MGO: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_sts.mul_fin) begin
                    n_state = S_MGO;
                    unique case (r_mop)
                        lslf_pkg::MOP_N_SXX:  n_mop = lslf_pkg::MOP_SX_SX;
                        lslf_pkg::MOP_SX_SX:  n_mop = lslf_pkg::MOP_SY_SXX;
                        lslf_pkg::MOP_SY_SXX: n_mop = lslf_pkg::MOP_SX_SXY;
                        lslf_pkg::MOP_SX_SXY: n_mop = lslf_pkg::MOP_N_SXY;
                        lslf_pkg::MOP_N_SXY:  n_mop = lslf_pkg::MOP_SX_SY;
                        lslf_pkg::MOP_SX_SY: begin
                            // a singular set skips both divisions
                            if (i_sts.singular) begin
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_DGO;
                                n_dsel  = lslf_pkg::DSEL_A;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_DGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.div_fin) begin
                    if (r_dsel == lslf_pkg::DSEL_A) begin
                        n_dsel  = lslf_pkg::DSEL_B;
                        n_state = S_DGO;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (r_chan == lslf_pkg::CHAN_W'(lslf_pkg::NCHAN - 1)) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_chan  = r_chan + 1'b1;
                    n_mop   = lslf_pkg::MOP_SY_SXX;
                    n_state = S_MGO;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

>>> hw/rtl/lslf_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_dpath
// Accumulators, a bit-serial signed multiplier, a restoring divider with
// rounding and saturation, and the result registers.
// ----------------------------------------------------------------------------
module lslf_dpath (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  lslf_pkg::t_cmd                              i_cmd,
    input  wire logic [lslf_pkg::IN_W-1:0]              i_x_value,
    input  wire logic [lslf_pkg::IN_W-1:0]              i_resp_one,
    input  wire logic [lslf_pkg::IN_W-1:0]              i_resp_two,
    input  wire logic [lslf_pkg::IN_W-1:0]              i_resp_three,
    output lslf_pkg::t_sts                              o_sts,
    output logic                                        o_valid,
    output logic [lslf_pkg::CHAN_W-1:0]                 o_channel,
    output logic signed [lslf_pkg::OUT_W-1:0]           o_intercept,
    output logic signed [lslf_pkg::OUT_W-1:0]           o_slope,
    output logic                                        o_singular,
    output logic                                        o_overflowed,
    output logic                                        o_run_end
);

    localparam int SB     = lslf_pkg::SAMPLE_BITS;
    localparam int SX_W   = lslf_pkg::SX_W;
    localparam int SXX_W  = lslf_pkg::SXX_W;
    localparam int AW     = lslf_pkg::MUL_AW;
    localparam int BW     = lslf_pkg::MUL_BW;
    localparam int PW     = lslf_pkg::PROD_W;
    localparam int DW     = lslf_pkg::DVD_W;
    localparam int QW     = lslf_pkg::Q_W;
    localparam int OW     = lslf_pkg::OUT_W;
    localparam int CW     = lslf_pkg::CNT_W;
    localparam int NCH    = lslf_pkg::NCHAN;

    // ---------------- sample registers and accumulators ----------------
    logic                  r_pend;
    logic [SB-1:0]         r_xs;
    logic [SB-1:0]         r_ys [NCH];
    logic [CW-1:0]         r_cnt;
    logic [SX_W-1:0]       r_sx;
    logic [SXX_W-1:0]      r_sxx;
    logic [SX_W-1:0]       r_sy  [NCH];
    logic [SXX_W-1:0]      r_sxy [NCH];
    logic                  r_drop;

    logic signed [2*SB-1:0] xx_prod;
    logic signed [2*SB-1:0] xy_prod [NCH];

    always_comb begin
        xx_prod = $signed(r_xs) * $signed(r_xs);
        for (int c = 0; c < NCH; c++) begin
            xy_prod[c] = $signed(r_xs) * $signed(r_ys[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xs    <= i_x_value[SB-1:0];
            r_ys[0] <= i_resp_one[SB-1:0];
            r_ys[1] <= i_resp_two[SB-1:0];
            r_ys[2] <= i_resp_three[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_pend <= 1'b0;
            r_cnt  <= '0;
            r_sx   <= '0;
            r_sxx  <= '0;
            r_drop <= 1'b0;
            for (int c = 0; c < NCH; c++) begin
                r_sy[c]  <= '0;
                r_sxy[c] <= '0;
            end
        end else begin
            r_pend <= i_cmd.load;
            if (r_pend) begin
                if (r_cnt < CW'(lslf_pkg::MAX_SAMPLES)) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_sx  <= r_sx + SX_W'($signed(r_xs));
                    r_sxx <= r_sxx + SXX_W'(xx_prod);
                    for (int c = 0; c < NCH; c++) begin
                        r_sy[c]  <= r_sy[c] + SX_W'($signed(r_ys[c]));
                        r_sxy[c] <= r_sxy[c] + SXX_W'(xy_prod[c]);
                    end
                end else begin
                    r_drop <= 1'b1;
                end
            end
        end
    end

    // ---------------- bit-serial multiplier (MSB first, sign bit negative) -----
    logic [AW-1:0]                 sel_a;
    logic [BW-1:0]                 sel_b;
    logic [AW-1:0]                 r_ma;
    logic [BW-1:0]                 r_mb;
    logic [PW-1:0]                 r_macc;
    logic [lslf_pkg::MCNT_W-1:0]   r_mcnt;
    logic                          r_mrun;
    logic                          r_mfin;
    logic [PW-1:0]                 mb_ext;
    logic [PW-1:0]                 mterm;

    always_comb begin
        sel_a = '0;
        sel_b = '0;
        unique case (i_cmd.mop)
            lslf_pkg::MOP_N_SXX: begin
                sel_a = AW'(r_cnt);
                sel_b = r_sxx;
            end
            lslf_pkg::MOP_SX_SX: begin
                sel_a = r_sx;
                sel_b = BW'($signed(r_sx));
            end
            lslf_pkg::MOP_SY_SXX: begin
                sel_a = r_sy[i_cmd.chan];
                sel_b = r_sxx;
            end
            lslf_pkg::MOP_SX_SXY: begin
                sel_a = r_sx;
                sel_b = r_sxy[i_cmd.chan];
            end
            lslf_pkg::MOP_N_SXY: begin
                sel_a = AW'(r_cnt);
                sel_b = r_sxy[i_cmd.chan];
            end
            lslf_pkg::MOP_SX_SY: begin
                sel_a = r_sx;
                sel_b = BW'($signed(r_sy[i_cmd.chan]));
            end
            default: begin
                sel_a = '0;
                sel_b = '0;
            end
        endcase
    end

    always_comb begin
        mb_ext = PW'($signed(r_mb));
        mterm  = '0;
        if (r_ma[AW-1]) begin
            mterm = (r_mcnt == lslf_pkg::MCNT_W'(AW)) ? (~mb_ext + 1'b1) : mb_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mrun <= 1'b0;
            r_mfin <= 1'b0;
        end else begin
            r_mfin <= 1'b0;
            if (i_cmd.mul_start) begin
                r_mrun <= 1'b1;
            end else if (r_mrun && r_mcnt == lslf_pkg::MCNT_W'(1)) begin
                r_mrun <= 1'b0;
                r_mfin <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_ma   <= sel_a;
            r_mb   <= sel_b;
            r_macc <= '0;
            r_mcnt <= lslf_pkg::MCNT_W'(AW);
        end else if (r_mrun) begin
            r_ma   <= r_ma << 1;
            r_macc <= (r_macc << 1) + mterm;
            r_mcnt <= r_mcnt - 1'b1;
        end
    end

    // ---------------- products into numerators and denominator ----------
    logic [PW-1:0] r_t0;
    logic [PW-1:0] r_den;
    logic [PW-1:0] r_na;
    logic [PW-1:0] r_nb;
    logic          singular;

    always_ff @(posedge i_clk) begin
        if (r_mfin) begin
            unique case (i_cmd.mop)
                lslf_pkg::MOP_N_SXX,
                lslf_pkg::MOP_SY_SXX,
                lslf_pkg::MOP_N_SXY:  r_t0  <= r_macc;
                lslf_pkg::MOP_SX_SX:  r_den <= r_t0 - r_macc;
                lslf_pkg::MOP_SX_SXY: r_na  <= r_t0 - r_macc;
                lslf_pkg::MOP_SX_SY:  r_nb  <= r_t0 - r_macc;
                default:              r_t0  <= r_t0;
            endcase
        end
    end

    assign singular = r_den[PW-1] || (r_den == '0);

    // ---------------- restoring divider, rounded and saturated ----------
    logic [PW-1:0]                 dnum;
    logic [PW-1:0]                 dmag;
    logic [DW-1:0]                 r_dvd;
    logic [PW-1:0]                 r_rem;
    logic [QW-1:0]                 r_q;
    logic                          r_qovf;
    logic                          r_dneg;
    logic [lslf_pkg::DCNT_W-1:0]   r_dcnt;
    logic                          r_drun;
    logic                          r_dfin;
    logic [PW:0]                   rem2;
    logic                          dge;
    logic                          big_pos;
    logic                          big_neg;
    logic [OW-1:0]                 sat_res;
    logic [OW-1:0]                 r_int;
    logic [OW-1:0]                 r_slp;

    assign dnum = (i_cmd.dsel == lslf_pkg::DSEL_A) ? r_na : r_nb;
    assign dmag = dnum[PW-1] ? (~dnum + 1'b1) : dnum;
    assign rem2 = {r_rem, r_dvd[DW-1]};
    assign dge  = (rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drun <= 1'b0;
            r_dfin <= 1'b0;
        end else begin
            r_dfin <= 1'b0;
            if (i_cmd.div_start) begin
                r_drun <= 1'b1;
            end else if (r_drun && r_dcnt == lslf_pkg::DCNT_W'(1)) begin
                r_drun <= 1'b0;
                r_dfin <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            // numerator magnitude scaled, plus half the divisor for rounding
            r_dvd  <= (DW'(dmag) << lslf_pkg::FRAC_BITS) + DW'(r_den >> 1);
            r_dneg <= dnum[PW-1];
            r_rem  <= '0;
            r_q    <= '0;
            r_qovf <= 1'b0;
            r_dcnt <= lslf_pkg::DCNT_W'(DW);
        end else if (r_drun) begin
            r_dvd  <= r_dvd << 1;
            r_rem  <= dge ? PW'(rem2 - {1'b0, r_den}) : PW'(rem2);
            r_q    <= {r_q[QW-2:0], dge};
            r_qovf <= r_qovf | r_q[QW-1];
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_comb begin
        big_pos = r_qovf | r_q[QW-1] | r_q[QW-2];
        big_neg = r_qovf | r_q[QW-1] | (r_q[QW-2] & (|r_q[QW-3:0]));
        if (!r_dneg) begin
            sat_res = big_pos ? {1'b0, {(OW-1){1'b1}}} : r_q[OW-1:0];
        end else begin
            sat_res = big_neg ? {1'b1, {(OW-1){1'b0}}} : (~r_q[OW-1:0] + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dfin) begin
            if (i_cmd.dsel == lslf_pkg::DSEL_A) begin
                r_int <= sat_res;
            end else begin
                r_slp <= sat_res;
            end
        end
    end

    // ---------------- result registers ----------------
    logic                              r_o_valid;
    logic [lslf_pkg::CHAN_W-1:0]       r_o_chan;
    logic [OW-1:0]                     r_o_int;
    logic [OW-1:0]                     r_o_slp;
    logic                              r_o_sing;
    logic                              r_o_ovf;
    logic                              r_o_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_chan <= i_cmd.chan;
            r_o_int  <= singular ? '0 : r_int;
            r_o_slp  <= singular ? '0 : r_slp;
            r_o_sing <= singular;
            r_o_ovf  <= r_drop;
            r_o_end  <= (i_cmd.chan == lslf_pkg::CHAN_W'(NCH - 1));
        end
    end

    assign o_sts.mul_fin  = r_mfin;
    assign o_sts.div_fin  = r_dfin;
    assign o_sts.singular = singular;

    assign o_valid      = r_o_valid;
    assign o_channel    = r_o_chan;
    assign o_intercept  = r_o_int;
    assign o_slope      = r_o_slp;
    assign o_singular   = r_o_sing;
    assign o_overflowed = r_o_ovf;
    assign o_run_end    = r_o_end;

    // ---------------- checks ----------------
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mrun && r_drun))
        else $error("multiplier and divider active together");

    a_results_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |=> !r_o_valid)
        else $error("back-to-back results");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(lslf_pkg::MAX_SAMPLES))
        else $error("sample count beyond capacity");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_sing) |-> (r_o_int == '0 && r_o_slp == '0))
        else $error("singular fit with nonzero coefficients");

    a_load_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && !i_cmd.clear) |=> r_pend)
        else $error("accepted sample not queued for accumulation");

endmodule
`default_nettype wire
